>>> hw/rtl/etuv_pkg.sv
// Shared types and constants for the encoder turn unwrap and velocity unit.
package etuv_pkg;

   // Fixed field widths of the channels and registers.
   localparam int SENSOR_W    = 16;
   localparam int TS_W        = 32;
   localparam int ANGLE_OUT_W = 14;
   localparam int VEL_W       = 32;
   localparam int THR_W       = 14;
   localparam int TPS_W       = 20;
   localparam int ERR_BIT     = 14;

   // Configuration port geometry.
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_IDX_BIT = 2;

   // Register indexes, decoded from one address bit.
   localparam logic REG_WRAP_THRESHOLD   = 1'b0;
   localparam logic REG_TICKS_PER_SECOND = 1'b1;

   // Register reset values.
   localparam logic [THR_W-1:0] WRAP_THRESHOLD_RST   = THR_W'(13107);
   localparam logic [TPS_W-1:0] TICKS_PER_SECOND_RST = TPS_W'(1000);

   // Request kinds.
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;

   // Saturation limits of the velocity result.
   localparam logic [VEL_W-1:0] VEL_MAX = 32'h7fff_ffff;
   localparam logic [VEL_W-1:0] VEL_MIN = 32'h8000_0000;

   // Sequencer states of the top level.
   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_ABS  = 6'b000010,
      ST_MUL  = 6'b000100,
      ST_DIV  = 6'b001000,
      ST_SAT  = 6'b010000,
      ST_DONE = 6'b100000
   } seq_state_type;

endpackage

>>> hw/rtl/etuv_req_if.sv
// Request channel interface: encoder samples and velocity queries.
interface etuv_req_if
   import etuv_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                req_type;
   logic [SENSOR_W-1:0] sensor_word;
   logic [TS_W-1:0]     timestamp;

   modport source (output valid, output req_type, output sensor_word, output timestamp,
                   input ready);
   modport sink (input valid, input req_type, input sensor_word, input timestamp,
                 output ready);
endinterface

>>> hw/rtl/etuv_rsp_if.sv
// Response channel interface: position, angle and velocity results.
interface etuv_rsp_if
   import etuv_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic                   sensor_error;
   logic [ANGLE_OUT_W-1:0] angle;
   logic signed [31:0]     position;
   logic signed [VEL_W-1:0] velocity;
   logic                   vel_saturated;

   modport source (output valid, output sensor_error, output angle, output position,
                   output velocity, output vel_saturated, input ready);
   modport sink (input valid, input sensor_error, input angle, input position,
                 input velocity, input vel_saturated, output ready);
endinterface

>>> hw/rtl/encoder_turn_unwrap_velocity_unit.sv
// Top level of the encoder multi-turn unwrap and velocity unit.
//
// Usage: the request channel carries either an encoder sample (sensor word and
// timestamp) or a velocity query. Every request gives exactly one response
// beat with the sensor error flag, the last good angle, the multi-turn
// position and, for queries, the saturated velocity in counts per second.
// A sample goes from acceptance straight to loading the response register.
// A query steps through magnitude, multiply (the divider registers the
// product as its dividend), the divide with one quotient bit per step of
// the TURN_BITS + ANGLE_BITS + 20 bit dividend in the restoring divider, a
// step to see it finish, clipping, and the response load. The divider sets
// the query latency, and a new request is accepted once the response loads.
// The request side is ready only while the sequencer is idle. The response
// register holds a finished beat while the receiver stalls, and a new request
// is still accepted; its result waits in the sequencer until the response
// register frees up. Reset clears the turn count, the sample and query
// snapshots and the primed flag, and restores the configuration registers
// (wrap threshold 13107, 1000 ticks per second).
module encoder_turn_unwrap_velocity_unit
   import etuv_pkg::*;
#(
   parameter int ANGLE_BITS = 14,
   parameter int TURN_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   etuv_req_if.sink              req_ch,
   etuv_rsp_if.source            rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int DP_W   = TURN_BITS + ANGLE_BITS + 1;
   localparam int MAG_W  = DP_W - 1;
   localparam int NUM_W  = MAG_W + TPS_W;
   localparam int CMP_W  = (ANGLE_BITS > THR_W) ? ANGLE_BITS : THR_W;
   localparam int POS_W  = TURN_BITS + ANGLE_BITS;

   // Sequencer and handshake state.
   seq_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Configuration registers.
   logic [THR_W-1:0] wrap_thr_ff, wrap_thr_in;
   logic [TPS_W-1:0] tps_ff, tps_in;

   // Tracking state.
   logic [ANGLE_BITS-1:0] last_angle_ff, last_angle_in;
   logic [TURN_BITS-1:0]  turn_count_ff, turn_count_in;
   logic [TS_W-1:0]       last_time_ff, last_time_in;
   logic [ANGLE_BITS-1:0] vel_angle_ff, vel_angle_in;
   logic [TURN_BITS-1:0]  vel_turns_ff, vel_turns_in;
   logic [TS_W-1:0]       vel_time_ff, vel_time_in;
   logic                  primed_ff, primed_in;

   // Velocity datapath registers.
   logic signed [DP_W-1:0] dpos_ff, dpos_in;
   logic [TS_W-1:0]        elapsed_ff, elapsed_in;
   logic [MAG_W-1:0]       mag_ff, mag_in;
   logic                   neg_ff, neg_in;

   // Pending result and response registers.
   logic                   res_err_ff, res_err_in;
   logic [VEL_W-1:0]       res_vel_ff, res_vel_in;
   logic                   res_sat_ff, res_sat_in;
   logic                   out_err_ff, out_err_in;
   logic [ANGLE_OUT_W-1:0] out_angle_ff, out_angle_in;
   logic [31:0]            out_pos_ff, out_pos_in;
   logic [VEL_W-1:0]       out_vel_ff, out_vel_in;
   logic                   out_sat_ff, out_sat_in;

   // Combinational helpers.
   logic                      req_fire;
   logic                      csr_write;
   logic [ANGLE_BITS-1:0]     angle_new;
   logic signed [ANGLE_BITS:0] adelta;
   logic [ANGLE_BITS-1:0]     amag;
   logic                      jump;
   logic [TURN_BITS-1:0]      tdiff;
   logic signed [DP_W-1:0]    tpart;
   logic signed [ANGLE_BITS:0] adiff;
   logic [TS_W-1:0]           tdelta;
   logic [NUM_W-1:0]          product;
   logic signed [POS_W-1:0]   pos_cat;
   logic                      div_start;
   logic                      div_done;
   logic [NUM_W-1:0]          quotient;
   logic                      sat_pos;
   logic                      sat_neg;

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Divider for the velocity quotient.
   etuv_divider #(
      .DIVIDEND_W (NUM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product),
      .divisor  (elapsed_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // Configuration writes and reads.
   always_comb begin
      wrap_thr_in = wrap_thr_ff;
      tps_in      = tps_ff;
      if (csr_write) begin
         unique case (csr_paddr[CSR_IDX_BIT])
            REG_WRAP_THRESHOLD:   wrap_thr_in = csr_pwdata[THR_W-1:0];
            REG_TICKS_PER_SECOND: tps_in      = csr_pwdata[TPS_W-1:0];
            default:              wrap_thr_in = wrap_thr_ff;
         endcase
      end
      unique case (csr_paddr[CSR_IDX_BIT])
         REG_WRAP_THRESHOLD:   csr_prdata = CSR_DATA_W'(wrap_thr_ff);
         REG_TICKS_PER_SECOND: csr_prdata = CSR_DATA_W'(tps_ff);
         default:              csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;

   // Sample unwrap, query snapshot differences, velocity product and clip checks.
   always_comb begin
      angle_new = req_ch.sensor_word[ANGLE_BITS-1:0];
      adelta    = $signed({1'b0, angle_new}) - $signed({1'b0, last_angle_ff});
      amag      = adelta[ANGLE_BITS] ? ANGLE_BITS'(-adelta) : ANGLE_BITS'(adelta);
      jump      = CMP_W'(amag) > CMP_W'(wrap_thr_ff);
      tdiff     = turn_count_ff - vel_turns_ff;
      tpart     = $signed({tdiff[TURN_BITS-1], tdiff, {ANGLE_BITS{1'b0}}});
      adiff     = $signed({1'b0, last_angle_ff}) - $signed({1'b0, vel_angle_ff});
      tdelta    = last_time_ff - vel_time_ff;
      product   = NUM_W'(mag_ff) * NUM_W'(tps_ff);
      pos_cat   = $signed({turn_count_ff, last_angle_ff});
      sat_pos   = |quotient[NUM_W-1:VEL_W-1];
      sat_neg   = (|quotient[NUM_W-1:VEL_W]) ||
                  (quotient[VEL_W-1] && (|quotient[VEL_W-2:0]));
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      last_angle_in = last_angle_ff;
      turn_count_in = turn_count_ff;
      last_time_in  = last_time_ff;
      vel_angle_in  = vel_angle_ff;
      vel_turns_in  = vel_turns_ff;
      vel_time_in   = vel_time_ff;
      primed_in     = primed_ff;
      dpos_in       = dpos_ff;
      elapsed_in    = elapsed_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      res_err_in    = res_err_ff;
      res_vel_in    = res_vel_ff;
      res_sat_in    = res_sat_ff;
      out_err_in    = out_err_ff;
      out_angle_in  = out_angle_ff;
      out_pos_in    = out_pos_ff;
      out_vel_in    = out_vel_ff;
      out_sat_in    = out_sat_ff;
      div_start     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               res_vel_in = '0;
               res_sat_in = 1'b0;
               res_err_in = 1'b0;
               if (req_ch.req_type == REQ_SAMPLE) begin
                  state_in = ST_DONE;
                  if (req_ch.sensor_word[ERR_BIT]) begin
                     res_err_in = 1'b1;
                  end else if (!primed_ff) begin
                     // The first good sample only primes both snapshots.
                     last_angle_in = angle_new;
                     vel_angle_in  = angle_new;
                     last_time_in  = req_ch.timestamp;
                     vel_time_in   = req_ch.timestamp;
                     primed_in     = 1'b1;
                  end else begin
                     // A large upward jump means the shaft crossed zero backward, a downward one forward.
                     if (jump) begin
                        if (adelta[ANGLE_BITS]) begin
                           turn_count_in = turn_count_ff + TURN_BITS'(1);
                        end else begin
                           turn_count_in = turn_count_ff - TURN_BITS'(1);
                        end
                     end
                     last_angle_in = angle_new;
                     last_time_in  = req_ch.timestamp;
                  end
               end else begin
                  // Capture the differences, then move the query snapshot forward.
                  state_in     = ST_ABS;
                  dpos_in      = tpart + DP_W'(adiff);
                  elapsed_in   = (tdelta == '0) ? TS_W'(1) : tdelta;
                  vel_angle_in = last_angle_ff;
                  vel_turns_in = turn_count_ff;
                  vel_time_in  = last_time_ff;
               end
            end
         end
         ST_ABS: begin
            neg_in   = dpos_ff[DP_W-1];
            mag_in   = dpos_ff[DP_W-1] ? MAG_W'(-dpos_ff) : MAG_W'(dpos_ff);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // The divider registers the product as its dividend.
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_SAT;
            end
         end
         ST_SAT: begin
            // Clip the magnitude quotient to the signed 32-bit range.
            if (neg_ff) begin
               res_sat_in = sat_neg;
               res_vel_in = sat_neg ? VEL_MIN : -quotient[VEL_W-1:0];
            end else begin
               res_sat_in = sat_pos;
               res_vel_in = sat_pos ? VEL_MAX : quotient[VEL_W-1:0];
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               out_err_in   = res_err_ff;
               out_angle_in = ANGLE_OUT_W'(last_angle_ff);
               out_pos_in   = 32'(pos_cat);
               out_vel_in   = res_vel_ff;
               out_sat_in   = res_sat_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control, configuration and tracking state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         wrap_thr_ff   <= WRAP_THRESHOLD_RST;
         tps_ff        <= TICKS_PER_SECOND_RST;
         last_angle_ff <= '0;
         turn_count_ff <= '0;
         last_time_ff  <= '0;
         vel_angle_ff  <= '0;
         vel_turns_ff  <= '0;
         vel_time_ff   <= '0;
         primed_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         wrap_thr_ff   <= wrap_thr_in;
         tps_ff        <= tps_in;
         last_angle_ff <= last_angle_in;
         turn_count_ff <= turn_count_in;
         last_time_ff  <= last_time_in;
         vel_angle_ff  <= vel_angle_in;
         vel_turns_ff  <= vel_turns_in;
         vel_time_ff   <= vel_time_in;
         primed_ff     <= primed_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      dpos_ff      <= dpos_in;
      elapsed_ff   <= elapsed_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      res_err_ff   <= res_err_in;
      res_vel_ff   <= res_vel_in;
      res_sat_ff   <= res_sat_in;
      out_err_ff   <= out_err_in;
      out_angle_ff <= out_angle_in;
      out_pos_ff   <= out_pos_in;
      out_vel_ff   <= out_vel_in;
      out_sat_ff   <= out_sat_in;
   end

   // Channel outputs.
   assign req_ch.ready         = (state_ff == ST_IDLE);
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.sensor_error  = out_err_ff;
   assign rsp_ch.angle         = out_angle_ff;
   assign rsp_ch.position      = $signed(out_pos_ff);
   assign rsp_ch.velocity      = $signed(out_vel_ff);
   assign rsp_ch.vel_saturated = out_sat_ff;

`ifndef ASSERT_OFF
   // A query always starts the velocity sequence with the magnitude step.
   a_query_to_abs: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_ch.req_type == REQ_QUERY) |=> (state_ff == ST_ABS))
      else $error("query did not enter the velocity sequence");

   // The divider only finishes while the sequencer waits for it.
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");

   // A clipped velocity is one of the two range limits.
   a_sat_limits: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_sat_ff) |-> (out_vel_ff == VEL_MAX || out_vel_ff == VEL_MIN))
      else $error("saturated velocity is not a range limit");

   // A dropped sample reports no velocity.
   a_err_no_vel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_err_ff) |-> (out_vel_ff == '0 && !out_sat_ff))
      else $error("error beat carries a velocity");
`endif

endmodule

>>> hw/rtl/etuv_divider.sv
// Restoring unsigned divider that retires one quotient bit per cycle.
module etuv_divider
   import etuv_pkg::*;
#(
   parameter int DIVIDEND_W = 52
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [TS_W-1:0]       divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [TS_W-1:0]       rem_ff, rem_in;
   logic [TS_W-1:0]       dvs_ff, dvs_in;
   logic [TS_W:0]         shifted;
   logic [TS_W+1:0]       trial;

   // One trial subtraction of the divisor from the shifted partial remainder.
   always_comb begin
      shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
      trial   = {1'b0, shifted} - {2'b00, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (trial[TS_W+1]) begin
            rem_in = shifted[TS_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end else begin
            rem_in = trial[TS_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
